@@ src/u16u8_pkg.sv @@
package u16u8_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       char_last;
    logic       stream_done;
    logic       error_flag;
  } out_item_t;

  // one classified character (or error) waiting for the serializer
  typedef struct packed {
    logic        err;
    logic        done;
    logic [20:0] cp;
  } job_t;

  localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  localparam logic [1:0] LEN1 = 2'd0;
  localparam logic [1:0] LEN2 = 2'd1;
  localparam logic [1:0] LEN3 = 2'd2;
  localparam logic [1:0] LEN4 = 2'd3;

  // utf-8 length minus one for a code point
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp[20:16] != 5'd0) begin
      n = LEN4;
    end else if (cp[15:11] != 5'd0) begin
      n = LEN3;
    end else if (cp[10:7] != 4'd0) begin
      n = LEN2;
    end else begin
      n = LEN1;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input logic [1:0] len_m1,
                                              input logic [1:0] k);
    logic [1:0] grp;
    logic [5:0] bits;
    logic [7:0] b;
    grp = len_m1 - k;
    case (grp)
      2'd0:    bits = cp[5:0];
      2'd1:    bits = cp[11:6];
      2'd2:    bits = cp[17:12];
      default: bits = 6'd0;
    endcase
    if (k != 2'd0) begin
      b = {2'b10, bits};
    end else begin
      unique case (len_m1)
        LEN1:    b = {1'b0, cp[6:0]};
        LEN2:    b = {3'b110, cp[10:6]};
        LEN3:    b = {4'b1110, cp[15:12]};
        LEN4:    b = {5'b11110, cp[20:18]};
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

endpackage

@@ src/utf16_to_utf8_transcoder_top.sv @@
// path: the first utf-8 byte of a character passes through the queue write, then the serializer
// load, after the transfer of the byte that completes its code unit
// throughput: one input byte per cycle while the 2-entry job queue has room; the output
// port moves one utf-8 byte per cycle while out_ready is high, so a stream of 3-byte
// characters is limited by the serializer
// reset: rst (synchronous) clears stream state, empties the queue, selects low byte first
module utf16_to_utf8_transcoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_item
);

  logic            q_push_valid, q_push_ready;
  u16u8_pkg::job_t q_push_data;
  logic            q_pop_valid, q_pop_ready;
  u16u8_pkg::job_t q_pop_data;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ src/u16u8_front.sv @@
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  u16u8_pkg::in_item_t in_item,
  output logic                push_valid,
  input  logic                push_ready,
  output u16u8_pkg::job_t     push_data
);

  logic        lo_first;
  logic [7:0]  held_byte, held_byte_next;
  logic        byte_phase, byte_phase_next;
  logic        high_pending, high_pending_next;
  logic [9:0]  high_bits, high_bits_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic        gen;
  logic [15:0] unit;
  logic        is_high, is_low;

  // a byte is only taken when its possible job has room
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign push_valid = accept && gen;

  assign unit = lo_first ? {in_item.in_byte, held_byte} : {held_byte, in_item.in_byte};
  assign is_high = (unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
  assign is_low  = (unit[15:10] == u16u8_pkg::SURR_LOW_TAG);

  always_comb begin
    logic err_hit;
    logic clear;
    err_hit = 1'b0;
    clear   = 1'b0;
    gen     = 1'b0;
    push_data = '0;
    held_byte_next    = held_byte;
    byte_phase_next   = byte_phase;
    high_pending_next = high_pending;
    high_bits_next    = high_bits;
    error_seen_next   = error_seen;

    if (error_seen) begin
      clear = in_item.stream_last;
    end else if (!byte_phase) begin
      if (in_item.stream_last) begin
        err_hit = 1'b1;
      end else begin
        held_byte_next  = in_item.in_byte;
        byte_phase_next = 1'b1;
      end
    end else begin
      byte_phase_next = 1'b0;
      if (high_pending) begin
        if (!is_low) begin
          err_hit = 1'b1;
        end else begin
          gen = 1'b1;
          push_data.cp = {1'b0, high_bits, unit[9:0]} + u16u8_pkg::SUPP_BASE;
          high_pending_next = 1'b0;
          high_bits_next    = 10'd0;
        end
      end else if (is_high) begin
        if (in_item.stream_last) begin
          err_hit = 1'b1;
        end else begin
          high_pending_next = 1'b1;
          high_bits_next    = unit[9:0];
        end
      end else if (is_low) begin
        err_hit = 1'b1;
      end else begin
        gen = 1'b1;
        push_data.cp = {5'd0, unit};
      end
      if (gen && in_item.stream_last) begin
        clear = 1'b1;
      end
    end

    if (err_hit) begin
      gen = 1'b1;
      push_data.err = 1'b1;
      push_data.cp  = '0;
      if (in_item.stream_last) begin
        clear = 1'b1;
      end else begin
        error_seen_next   = 1'b1;
        byte_phase_next   = 1'b0;
        high_pending_next = 1'b0;
        high_bits_next    = 10'd0;
        held_byte_next    = 8'd0;
      end
    end
    push_data.done = in_item.stream_last;

    if (clear) begin
      held_byte_next    = 8'd0;
      byte_phase_next   = 1'b0;
      high_pending_next = 1'b0;
      high_bits_next    = 10'd0;
      error_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_first <= 1'b1;
    end else if (cfg_we) begin
      lo_first <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte    <= 8'd0;
      byte_phase   <= 1'b0;
      high_pending <= 1'b0;
      high_bits    <= 10'd0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      held_byte    <= held_byte_next;
      byte_phase   <= byte_phase_next;
      high_pending <= high_pending_next;
      high_bits    <= high_bits_next;
      error_seen   <= error_seen_next;
    end
  end

  // dropping mode always starts from a clean code-unit boundary
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (!byte_phase && !high_pending))
    else $error("front: dropping with partial unit held");

  // an accepted byte with stream_last always ends the stream
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.stream_last) |=> (!byte_phase && !high_pending && !error_seen))
    else $error("front: stream state not cleared at stream end");

endmodule

@@ src/u16u8_queue.sv @@
module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  u16u8_pkg::job_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output u16u8_pkg::job_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16u8_pkg::job_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue: occupancy beyond depth");

endmodule

@@ src/u16u8_back.sv @@
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  u16u8_pkg::job_t      pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_item
);

  u16u8_pkg::job_t cur;
  logic            cur_valid;
  logic [1:0]      idx;
  logic [1:0]      len_m1;
  logic            is_final;
  logic            out_xfer;

  assign len_m1   = cur.err ? u16u8_pkg::LEN1 : u16u8_pkg::utf8_len_m1(cur.cp);
  assign is_final = (idx == len_m1);
  assign out_valid = cur_valid;
  assign out_xfer  = cur_valid && out_ready;
  // next job loads in the same cycle the last byte of this one transfers
  assign pop_ready = !cur_valid || (out_ready && is_final);

  always_comb begin
    out_item.utf8_byte   = cur.err ? 8'd0 : u16u8_pkg::utf8_byte_at(cur.cp, len_m1, idx);
    out_item.char_last   = is_final;
    out_item.stream_done = is_final && cur.done;
    out_item.error_flag  = cur.err;
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop_valid && pop_ready) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (out_xfer) begin
      if (is_final) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.err) |-> (idx == 2'd0))
    else $error("back: error result spans several bytes");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= len_m1))
    else $error("back: byte index past character length");

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DIRECTED_BYTES = 26;
  localparam logic LITTLE = 1'b1;
  localparam logic BIG    = 1'b0;

  typedef enum int {
    FAULT_NONE, FAULT_LONE_LOW, FAULT_BROKEN_PAIR, FAULT_TRAILING_HIGH,
    FAULT_ODD_COUNT, FAULT_NOISE
  } fault_t;

  typedef enum int {CLASS_ASCII, CLASS_TWO, CLASS_THREE, CLASS_FOUR} char_class_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  u16u8_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_ready;
  u16u8_pkg::out_item_t out_item;

  utf16_to_utf8_transcoder_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  // transcoder state as the testbench sees it
  logic                 order_le;
  logic [7:0]           first_byte;
  logic                 second_due;
  logic                 high_waiting;
  logic [9:0]           high_payload;
  logic                 dropping;
  u16u8_pkg::out_item_t utf8_expected[$];

  int  bytes_sent = 0;
  int  streams_sent = 0;
  int  config_writes = 0;
  int  results_checked = 0;
  int  error_results = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  function automatic void queue_result(u16u8_pkg::out_item_t r);
    utf8_expected = {utf8_expected, r};
  endfunction

  function automatic void end_stream();
    first_byte   = 8'h00;
    second_due   = 1'b0;
    high_waiting = 1'b0;
    high_payload = 10'd0;
    dropping     = 1'b0;
  endfunction

  function automatic void expect_error(logic last);
    queue_result('{utf8_byte: 8'h00, char_last: 1'b1, stream_done: last, error_flag: 1'b1});
    end_stream();
    // an error on the final byte clears right away, otherwise drop until stream end
    dropping = !last;
  endfunction

  function automatic void expect_code_point(logic [20:0] cp, logic last);
    logic [7:0] seq[4];
    int n;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      queue_result('{utf8_byte: seq[k], char_last: logic'(k == n - 1),
                     stream_done: logic'(k == n - 1) & last, error_flag: 1'b0});
    end
  endfunction

  function automatic void transcode_byte(u16u8_pkg::in_item_t it);
    logic [15:0] code_unit;
    logic [20:0] cp;
    if (dropping) begin
      if (it.stream_last) end_stream();
      return;
    end
    if (!second_due) begin
      if (it.stream_last) begin
        expect_error(1'b1);
        return;
      end
      first_byte = it.in_byte;
      second_due = 1'b1;
      return;
    end
    second_due = 1'b0;
    code_unit = order_le ? {it.in_byte, first_byte} : {first_byte, it.in_byte};
    if (high_waiting) begin
      if (code_unit[15:10] != u16u8_pkg::SURR_LOW_TAG) begin
        expect_error(it.stream_last);
        return;
      end
      cp = 21'h10000 + {high_payload, code_unit[9:0]};
      high_waiting = 1'b0;
      high_payload = 10'd0;
    end else if (code_unit[15:10] == u16u8_pkg::SURR_HIGH_TAG) begin
      if (it.stream_last) begin
        expect_error(1'b1);
        return;
      end
      high_waiting = 1'b1;
      high_payload = code_unit[9:0];
      return;
    end else if (code_unit[15:10] == u16u8_pkg::SURR_LOW_TAG) begin
      expect_error(it.stream_last);
      return;
    end else begin
      cp = {5'd0, code_unit};
    end
    expect_code_point(cp, it.stream_last);
    if (it.stream_last) end_stream();
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [20:0] random_code_point();
    logic [20:0] cp;
    case (char_class_t'($urandom_range(CLASS_ASCII, CLASS_FOUR)))
      CLASS_ASCII: cp = 21'($urandom_range(0, 'h7f));
      CLASS_TWO:   cp = 21'($urandom_range('h80, 'h7ff));
      CLASS_THREE: begin
        // skip the surrogate range
        cp = 21'($urandom_range('h800, 'hf7ff));
        if (cp >= 21'hd800) cp = cp + 21'h800;
      end
      default:     cp = 21'($urandom_range('h10000, 'h10ffff));
    endcase
    return cp;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, stream_last: last};
    do @(posedge clk); while (!in_ready);
    transcode_byte('{in_byte: b, stream_last: last});
    bytes_sent++;
    if (last) streams_sent++;
  endtask

  task automatic send_unit(logic [15:0] u, logic last);
    if (order_le) begin
      send_byte(u[7:0], 1'b0);
      send_byte(u[15:8], last);
    end else begin
      send_byte(u[15:8], 1'b0);
      send_byte(u[7:0], last);
    end
  endtask

  task automatic send_code_point(logic [20:0] cp, logic last);
    logic [19:0] v;
    if (cp < 21'h10000) begin
      send_unit(cp[15:0], last);
    end else begin
      v = 20'(cp - 21'h10000);
      send_unit({u16u8_pkg::SURR_HIGH_TAG, v[19:10]}, 1'b0);
      send_unit({u16u8_pkg::SURR_LOW_TAG, v[9:0]}, last);
    end
  endtask

  task automatic send_tail(int count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom), logic'(i == count - 1));
  endtask

  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_byte_order(logic le);
    wait_for_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= le;
    @(negedge clk);
    cfg_we    <= 1'b0;
    order_le = le;
    config_writes++;
  endtask

  task automatic send_random_stream();
    fault_t      fault;
    int          chars;
    logic        last;
    logic [15:0] u;
    chars = $urandom_range(1, 5);
    fault = ($urandom_range(0, 99) < 25) ?
            fault_t'($urandom_range(FAULT_LONE_LOW, FAULT_NOISE)) : FAULT_NONE;
    last  = logic'($urandom_range(0, 1));
    for (int i = 0; i < chars; i++) begin
      send_code_point(random_code_point(), logic'(fault == FAULT_NONE && i == chars - 1));
    end
    case (fault)
      FAULT_LONE_LOW: begin
        send_unit({u16u8_pkg::SURR_LOW_TAG, 10'($urandom)}, last);
        if (!last) send_tail($urandom_range(1, 4));
      end
      FAULT_BROKEN_PAIR: begin
        send_unit({u16u8_pkg::SURR_HIGH_TAG, 10'($urandom)}, 1'b0);
        u = 16'($urandom);
        if (u[15:10] == u16u8_pkg::SURR_LOW_TAG) u[10] = 1'b0;
        send_unit(u, last);
        if (!last) send_tail($urandom_range(1, 4));
      end
      FAULT_TRAILING_HIGH: send_unit({u16u8_pkg::SURR_HIGH_TAG, 10'($urandom)}, 1'b1);
      FAULT_ODD_COUNT:     send_byte(8'($urandom), 1'b1);
      FAULT_NOISE:         send_tail($urandom_range(1, 8));
      default: ;
    endcase
  endtask

  // reset byte order, one boundary code point for every utf-8 length
  task automatic test_encodings();
    send_code_point(21'h0, 1'b0);
    send_code_point(21'h80, 1'b0);
    send_code_point(21'hffff, 1'b0);
    send_code_point(21'h10ffff, 1'b1);
  endtask

  task automatic test_surrogate_errors();
    // lone low surrogate, then a byte that gets dropped and ends the stream
    send_unit(16'hdc00, 1'b0);
    send_byte(8'hff, 1'b1);
    // high surrogate followed by a plain unit on the last position
    send_unit(16'hd800, 1'b0);
    send_unit(16'h0041, 1'b1);
    // high surrogate as the final unit
    send_unit(16'hdbff, 1'b1);
    // odd byte count
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_big_endian();
    set_byte_order(BIG);
    send_code_point(21'he9, 1'b0);
    send_code_point(21'h1f600, 1'b1);
  endtask

  task automatic test_back_to_back();
    int stop;
    set_byte_order(LITTLE);
    idle_on = 1'b0;
    stop = bytes_sent + 50;
    while (bytes_sent < stop) send_random_stream();
    idle_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int stop;
    stop = DIRECTED_BYTES + 210;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 9) == 0) set_byte_order(logic'($urandom_range(0, 1)));
      send_random_stream();
    end
  endtask

  always @(negedge clk) out_ready <= !(idle_on && $urandom_range(0, 99) < 24);

  always @(posedge clk) begin : check_results
    u16u8_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (utf8_expected.size() == 0) begin
        $display("%0t ns: expected no result, actual byte %h char_last %b done %b error %b",
                 $time, out_item.utf8_byte, out_item.char_last, out_item.stream_done,
                 out_item.error_flag);
        mismatches++;
      end else begin
        want = utf8_expected.pop_front();
        check_field("utf8_byte", want.utf8_byte, out_item.utf8_byte);
        check_field("char_last", want.char_last, out_item.char_last);
        check_field("stream_done", want.stream_done, out_item.stream_done);
        check_field("error_flag", want.error_flag, out_item.error_flag);
        results_checked++;
        if (want.error_flag) error_results++;
      end
    end
  end

  // counts cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, %0d results outstanding", $time,
               utf8_expected.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    order_le  = LITTLE;
    end_stream();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_encodings();
    test_surrogate_errors();
    test_big_endian();
    test_back_to_back();
    test_random_streams();
    wait_for_quiet();

    $display("sent %0d utf-16 bytes in %0d streams, %0d byte order writes",
             bytes_sent, streams_sent, config_writes);
    $display("checked %0d utf-8 results, %0d of them error results",
             results_checked, error_results);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
